// ----- rtl/core/cdf_pkg.sv -----
// Shared types, codes and helpers for the chunk deframer with Fletcher-16 check.
// No dependencies; imported by the top level, the result queue and the checker.
`default_nettype none

package cdf_pkg;

    localparam int unsigned CFG_LEN_W = 17;
    localparam logic [8:0]  FLETCHER_MOD = 9'd255;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NACK = 2'd2,
        KIND_PERR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_SEQUENCE = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_SKIP     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_VERSION  = 2'd0,
        REG_END_TYPE = 2'd1,
        REG_MAX_LEN  = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_index_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       message_end;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(kind_t k, logic [7:0] b, logic e, logic l);
        result_t r;
        r.kind         = k;
        r.payload_byte = b;
        r.message_end  = e;
        r.last         = l;
        return r;
    endfunction

    // Both operands below 255 or a raw byte: one conditional subtract suffices.
    function automatic logic [7:0] add_mod255(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= FLETCHER_MOD)
            s = s - FLETCHER_MOD;
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cdf_result_queue.sv -----
// Small result queue: takes up to two results per cycle, hands out one while not stalled.
// Depends on cdf_pkg for the result and push types.
`default_nettype none

module cdf_result_queue
    import cdf_pkg::*;
#(
    parameter int unsigned ADDR_W = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      head
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    result_t              entry_reg [DEPTH];
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [ADDR_W-1:0]    tail_reg, tail_next;
    logic [ADDR_W:0]      count_reg, count_next;
    logic [ADDR_W-1:0]    tail_plus1;
    logic                 pop;

    assign out_valid  = (count_reg != '0);
    assign head       = entry_reg[head_reg];
    assign pop        = out_valid && !out_stall;
    assign room       = (count_reg <= (ADDR_W + 1)'(DEPTH - 2));
    assign tail_plus1 = tail_reg + 1'b1;

    always_comb
    begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + ADDR_W'(push.count);
        count_next = count_reg + (ADDR_W + 1)'(push.count) - (ADDR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[tail_plus1] <= push.second;
    end

endmodule

`default_nettype wire

// ----- rtl/core/chunk_deframer_fletcher16_unit.sv -----
// Top level of the chunk deframer with Fletcher-16 check.
// Depends on cdf_pkg and cdf_result_queue.
`default_nettype none

// Takes one received byte per cycle unless stalled. Each chunk is an 8-byte
// big-endian header (length, version, type, checksum), a 2-byte sequence number
// and the payload. In-sequence payload bytes come out at once as kind 0, then an
// accept or reject; bad version or oversized length gives a protocol error after
// the header. Every byte is handled in the cycle it is accepted; results pass
// through a four-entry queue, so one item is taken per cycle while the output
// keeps up, and in_stall rises only when fewer than two queue entries are free.
// The last payload byte of a chunk yields two results, which the queue absorbs.

module chunk_deframer_fletcher16_unit
    import cdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                kind,
    output logic [7:0]                payload_byte,
    output logic                      message_end,
    output logic                      last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_LEN_W-1:0] cfg_data
);

    localparam int unsigned CFG_MAX = (1 << CFG_LEN_W) - 1;
    localparam int unsigned LIMIT   = (MAX_PAYLOAD < CFG_MAX) ? MAX_PAYLOAD : CFG_MAX;
    localparam int unsigned CNT_W   = $clog2(LIMIT + 1);
    localparam logic [31:0] MAX_PAYLOAD_W = 32'(MAX_PAYLOAD);

    logic [7:0]           version_cfg_reg;
    logic [7:0]           end_type_cfg_reg;
    logic [CFG_LEN_W-1:0] max_len_cfg_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  index_reg, index_next;
    logic [31:0] length_reg, length_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] csum_reg, csum_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] exp_seq_reg, exp_seq_next;
    logic [7:0]  sum_lo_reg, sum_lo_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;

    logic        in_acc;
    logic        room;
    push_t       push;
    result_t     head;
    logic [7:0]  lo_upd, hi_upd;
    logic [CNT_W-1:0] left_dec;
    logic        bad_header;
    logic        is_end;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign in_acc    = in_valid && room;

    assign lo_upd     = add_mod255(sum_lo_reg, rx_byte);
    assign hi_upd     = add_mod255(sum_hi_reg, lo_upd);
    assign left_dec   = left_reg - 1'b1;
    assign is_end     = (type_reg == end_type_cfg_reg);
    assign bad_header = (version_reg != version_cfg_reg)
                     || (length_reg > {{(32 - CFG_LEN_W){1'b0}}, max_len_cfg_reg})
                     || (length_reg > MAX_PAYLOAD_W);

    always_comb
    begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        version_next = version_reg;
        type_next    = type_reg;
        csum_next    = csum_reg;
        seq_next     = seq_reg;
        exp_seq_next = exp_seq_reg;
        sum_lo_next  = sum_lo_reg;
        sum_hi_next  = sum_hi_reg;
        push.count   = 2'd0;
        push.first   = make_result(KIND_BYTE, 8'd0, 1'b0, 1'b0);
        push.second  = make_result(KIND_BYTE, 8'd0, 1'b0, 1'b0);

        if (in_acc)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (index_reg < 3'd4)
                        length_next = {length_reg[23:0], rx_byte};
                    else if (index_reg == 3'd4)
                        version_next = rx_byte;
                    else if (index_reg == 3'd5)
                        type_next = rx_byte;
                    else
                        csum_next = {csum_reg[7:0], rx_byte};

                    if (index_reg != 3'd7)
                        index_next = index_reg + 1'b1;
                    else
                    begin
                        index_next = 3'd0;
                        if (bad_header)
                        begin
                            push.count = 2'd1;
                            push.first = make_result(KIND_PERR, 8'd0, 1'b0, 1'b1);
                        end
                        else
                            phase_next = PH_SEQUENCE;
                    end
                end
                PH_SEQUENCE:
                begin
                    seq_next = {seq_reg[7:0], rx_byte};
                    if (index_reg == 3'd0)
                        index_next = 3'd1;
                    else
                    begin
                        index_next  = 3'd0;
                        sum_lo_next = 8'd0;
                        sum_hi_next = 8'd0;
                        left_next   = length_reg[CNT_W-1:0];
                        phase_next  = (seq_next == exp_seq_reg) ? PH_PAYLOAD : PH_SKIP;
                        if (length_reg == 32'd0)
                        begin
                            // empty chunk: verdict now, checksum of nothing is zero
                            phase_next = PH_HEADER;
                            push.count = 2'd1;
                            if (seq_next == exp_seq_reg && csum_reg == 16'd0)
                            begin
                                push.first   = make_result(KIND_ACK, 8'd0, is_end, 1'b1);
                                exp_seq_next = exp_seq_reg + 1'b1;
                            end
                            else
                                push.first = make_result(KIND_NACK, 8'd0, 1'b0, 1'b1);
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next   = left_dec;
                    sum_lo_next = lo_upd;
                    sum_hi_next = hi_upd;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                        push.count = 2'd2;
                        push.first = make_result(KIND_BYTE, rx_byte, 1'b0, 1'b0);
                        if ({hi_upd, lo_upd} == csum_reg)
                        begin
                            push.second  = make_result(KIND_ACK, 8'd0, is_end, 1'b1);
                            exp_seq_next = exp_seq_reg + 1'b1;
                        end
                        else
                            push.second = make_result(KIND_NACK, 8'd0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        push.count = 2'd1;
                        push.first = make_result(KIND_BYTE, rx_byte, 1'b0, 1'b1);
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                        push.count = 2'd1;
                        push.first = make_result(KIND_NACK, 8'd0, 1'b0, 1'b1);
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            index_reg   <= '0;
            length_reg  <= '0;
            left_reg    <= '0;
            version_reg <= '0;
            type_reg    <= '0;
            csum_reg    <= '0;
            seq_reg     <= '0;
            exp_seq_reg <= '0;
            sum_lo_reg  <= '0;
            sum_hi_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            csum_reg    <= csum_next;
            seq_reg     <= seq_next;
            exp_seq_reg <= exp_seq_next;
            sum_lo_reg  <= sum_lo_next;
            sum_hi_reg  <= sum_hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_cfg_reg  <= '0;
            end_type_cfg_reg <= '0;
            max_len_cfg_reg  <= CFG_LEN_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_VERSION:  version_cfg_reg  <= cfg_data[7:0];
                REG_END_TYPE: end_type_cfg_reg <= cfg_data[7:0];
                REG_MAX_LEN:  max_len_cfg_reg  <= cfg_data;
                REG_UNUSED:   ;
                default:      ;
            endcase
        end
    end

    cdf_result_queue #(
        .ADDR_W (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind         = head.kind;
    assign payload_byte = head.payload_byte;
    assign message_end  = head.message_end;
    assign last         = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/cdf_checker.sv -----
// Port-level checks on the result channel of the chunk deframer.
// Depends on cdf_pkg; bound to chunk_deframer_fletcher16_unit below.
`default_nettype none

module cdf_checker
    import cdf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] payload_byte,
    input wire logic       message_end,
    input wire logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
                                   && $stable(message_end) && $stable(last))
        else $error("result changed while stalled");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> last)
        else $error("verdict item without last");

    a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> payload_byte == 8'd0)
        else $error("verdict item carries a payload byte");

    a_end_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> kind == KIND_ACK)
        else $error("message end on an item that is not an accept");

endmodule

bind chunk_deframer_fletcher16_unit cdf_checker u_cdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .message_end  (message_end),
    .last         (last)
);

`default_nettype wire

// ----- verif/chunk_deframer_fletcher16_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for chunk_deframer_fletcher16_unit: directed table, then random chunks.
// Results are checked field by field against a built-in deframer model. Needs cdf_pkg and the RTL.

module chunk_deframer_fletcher16_unit_tb
    import cdf_pkg::*;
();

    localparam int unsigned MAX_PAYLOAD    = 65536;
    localparam int unsigned SUM_MOD        = 255;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          PHASE_BYTES    = 260;
    localparam int          N_PHASES       = 5;
    localparam int          IN_IDLE   [N_PHASES] = '{0, 72, 0, 21, 21};
    localparam int          OUT_STALL [N_PHASES] = '{0, 0, 72, 21, 21};

    localparam result_t R_NONE    = '0;
    localparam result_t R_ACK_END = '{KIND_ACK, 8'h00, 1'b1, 1'b1};
    localparam result_t R_PERR    = '{KIND_PERR, 8'h00, 1'b0, 1'b1};

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    localparam int N_ROWS = 29;
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        // empty chunk, sequence 0, end type: accept with end of message
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd1, R_ACK_END, R_NONE},
        // all-ones header: bad version and oversized length
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b1, 2'd1, R_PERR, R_NONE},
        // one-byte chunk, sequence 1, payload 0xFF sums to zero
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h01, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h01, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h00, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'h01, 1'b1, 2'd0, R_NONE, R_NONE},
        '{8'hFF, 1'b0, 2'd0, R_NONE, R_NONE}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte   = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic                 message_end;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = 2'd0;
    logic [CFG_LEN_W-1:0] cfg_data  = '0;

    // model state
    logic [7:0]           cfg_ver;
    logic [7:0]           cfg_end;
    logic [CFG_LEN_W-1:0] cfg_max;
    phase_t               ph;
    int unsigned          hdr_idx;
    logic [31:0]          chunk_len;
    logic [16:0]          left;
    logic [7:0]           ver_seen;
    logic [7:0]           type_seen;
    logic [15:0]          cks_hdr;
    logic [15:0]          seq_seen;
    logic [15:0]          seq_next;
    logic [7:0]           s_lo;
    logic [7:0]           s_hi;

    result_t              step_results [$];
    result_t              results_due [$];
    logic [7:0]           wire_bytes [$];
    int                   in_idle_pct   = 0;
    int                   out_stall_pct = 0;
    int                   mismatches    = 0;
    int                   bytes_sent    = 0;
    int                   idle_cycles   = 0;

    chunk_deframer_fletcher16_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .message_end  (message_end),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void close_chunk();
        result_t r;
        r = '0;
        r.last = 1'b1;
        if (ph == PH_SKIP || seq_seen != seq_next || {s_hi, s_lo} != cks_hdr)
            r.kind = KIND_NACK;
        else
        begin
            r.kind        = KIND_ACK;
            r.message_end = (type_seen == cfg_end);
            seq_next      = seq_next + 16'd1;
        end
        step_results.push_back(r);
        ph      = PH_HEADER;
        hdr_idx = 0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        step_results.delete();
        case (ph)
            PH_HEADER:
            begin
                if (hdr_idx < 4)
                    chunk_len = {chunk_len[23:0], b};
                else if (hdr_idx == 4)
                    ver_seen = b;
                else if (hdr_idx == 5)
                    type_seen = b;
                else
                    cks_hdr = {cks_hdr[7:0], b};
                if (hdr_idx != 7)
                    hdr_idx++;
                else
                begin
                    hdr_idx = 0;
                    if (ver_seen != cfg_ver || chunk_len > 32'(cfg_max)
                        || chunk_len > 32'(MAX_PAYLOAD))
                    begin
                        r.kind = KIND_PERR;
                        r.last = 1'b1;
                        step_results.push_back(r);
                    end
                    else
                        ph = PH_SEQUENCE;
                end
            end
            PH_SEQUENCE:
            begin
                seq_seen = {seq_seen[7:0], b};
                if (hdr_idx == 0)
                    hdr_idx = 1;
                else
                begin
                    hdr_idx = 0;
                    s_lo    = 8'h00;
                    s_hi    = 8'h00;
                    left    = chunk_len[16:0];
                    ph      = (seq_seen == seq_next) ? PH_PAYLOAD : PH_SKIP;
                    if (left == 0)
                        close_chunk();
                end
            end
            default:
            begin
                if (left != 0)
                    left--;
                if (ph == PH_PAYLOAD)
                begin
                    s_lo           = 8'((32'(s_lo) + 32'(b)) % SUM_MOD);
                    s_hi           = 8'((32'(s_hi) + 32'(s_lo)) % SUM_MOD);
                    r.kind         = KIND_BYTE;
                    r.payload_byte = b;
                    r.last         = (left != 0);
                    step_results.push_back(r);
                end
                if (left == 0)
                    close_chunk();
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        predict_byte(b);
    endtask

    task automatic send_wire_bytes();
        while (wire_bytes.size() != 0)
        begin
            send_byte(wire_bytes.pop_front());
            foreach (step_results[k])
                results_due.push_back(step_results[k]);
        end
    endtask

    function automatic void put_frame_head(input logic [31:0] len, input logic [7:0] ver,
                                           input logic [7:0] typ, input logic [15:0] cks,
                                           input logic [15:0] seq, input bit with_seq);
        wire_bytes.push_back(len[31:24]);
        wire_bytes.push_back(len[23:16]);
        wire_bytes.push_back(len[15:8]);
        wire_bytes.push_back(len[7:0]);
        wire_bytes.push_back(ver);
        wire_bytes.push_back(typ);
        wire_bytes.push_back(cks[15:8]);
        wire_bytes.push_back(cks[7:0]);
        if (with_seq)
        begin
            wire_bytes.push_back(seq[15:8]);
            wire_bytes.push_back(seq[7:0]);
        end
    endfunction

    task automatic send_random_chunk();
        logic [7:0]  body [$];
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [15:0] seq;
        logic [15:0] cks;
        logic [31:0] len;
        int unsigned limit;
        int unsigned pick;
        int unsigned n;
        limit = (cfg_max > CFG_LEN_W'(MAX_PAYLOAD)) ? MAX_PAYLOAD : int'(cfg_max);
        pick  = $urandom_range(99);
        if (pick >= 95)
        begin
            // truncated header run into junk with a wrong version byte
            n = $urandom_range(1, 4);
            repeat (n)
                wire_bytes.push_back(8'($urandom));
            repeat (8 - n)
                wire_bytes.push_back(~cfg_ver);
            send_wire_bytes();
            return;
        end
        len = $urandom_range(limit < 12 ? limit : 12);
        if ($urandom_range(9) == 0 && limit <= 64)
            len = limit;
        ver = cfg_ver;
        typ = $urandom_range(1) ? cfg_end : 8'($urandom);
        seq = seq_next;
        if (pick >= 90)
        begin
            len = $urandom_range(1) ? 32'(limit + 1 + $urandom_range(3))
                                    : ($urandom() | 32'h0002_0000);
            put_frame_head(len, ver, typ, 16'($urandom), seq, 1'b0);
            send_wire_bytes();
            return;
        end
        if (pick >= 85)
        begin
            ver = cfg_ver ^ 8'($urandom_range(1, 255));
            put_frame_head(len, ver, typ, 16'($urandom), seq, 1'b0);
            send_wire_bytes();
            return;
        end
        if (pick >= 77)
            seq = seq_next + 16'($urandom_range(1, 65535));
        lo = 8'h00;
        hi = 8'h00;
        for (int i = 0; i < int'(len); i++)
        begin
            b  = 8'($urandom);
            lo = 8'((32'(lo) + 32'(b)) % SUM_MOD);
            hi = 8'((32'(hi) + 32'(lo)) % SUM_MOD);
            body.push_back(b);
        end
        cks = {hi, lo};
        if (pick >= 70 && pick < 77)
            cks = cks ^ 16'($urandom_range(1, 65535));
        put_frame_head(len, ver, typ, cks, seq, 1'b1);
        foreach (body[i])
            wire_bytes.push_back(body[i]);
        send_wire_bytes();
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_LEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_VERSION:  cfg_ver = val[7:0];
            REG_END_TYPE: cfg_end = val[7:0];
            REG_MAX_LEN:  cfg_max = val;
            default:      ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic void flag_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        out_stall <= ($urandom_range(99) < out_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result with none expected, kind %0d byte %0h", $time, kind,
                         payload_byte);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (kind !== want.kind)
                    flag_field("kind", 8'(want.kind), 8'(kind));
                if (payload_byte !== want.payload_byte)
                    flag_field("payload_byte", want.payload_byte, payload_byte);
                if (message_end !== want.message_end)
                    flag_field("message_end", 8'(want.message_end), 8'(message_end));
                if (last !== want.last)
                    flag_field("last", 8'(want.last), 8'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL chunk_deframer_fletcher16_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0]           v;
        logic [7:0]           e;
        logic [CFG_LEN_W-1:0] m;
        int                   phase_start;
        cfg_ver   = 8'h00;
        cfg_end   = 8'h00;
        cfg_max   = CFG_LEN_W'(MAX_PAYLOAD);
        ph        = PH_HEADER;
        hdr_idx   = 0;
        chunk_len = '0;
        left      = '0;
        ver_seen  = '0;
        type_seen = '0;
        cks_hdr   = '0;
        seq_seen  = '0;
        seq_next  = '0;
        s_lo      = '0;
        s_hi      = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            send_byte(DIR_ROWS[i].rx);
            if (DIR_ROWS[i].typed)
            begin
                if (DIR_ROWS[i].n > 0)
                    results_due.push_back(DIR_ROWS[i].r0);
                if (DIR_ROWS[i].n > 1)
                    results_due.push_back(DIR_ROWS[i].r1);
            end
            else
                foreach (step_results[k])
                    results_due.push_back(step_results[k]);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            in_idle_pct   = IN_IDLE[p];
            out_stall_pct = OUT_STALL[p];
            v = 8'($urandom);
            e = 8'($urandom);
            case (p)
                0:
                begin
                    v = 8'hFF;
                    e = 8'hFF;
                    m = '1;
                end
                1:
                begin
                    v = 8'h00;
                    e = 8'h01;
                    m = CFG_LEN_W'(7);
                end
                2:       m = CFG_LEN_W'(65535);
                3:       m = '0;
                default: m = CFG_LEN_W'(MAX_PAYLOAD);
            endcase
            write_reg(REG_VERSION, CFG_LEN_W'(v));
            write_reg(REG_END_TYPE, CFG_LEN_W'(e));
            write_reg(REG_MAX_LEN, m);
            write_reg(REG_UNUSED, CFG_LEN_W'($urandom));
            cfg_valid <= 1'b0;

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_chunk();

            if (p == 0)
            begin
                // length one beyond the largest legal payload, register limit above it
                put_frame_head(32'(MAX_PAYLOAD + 1), cfg_ver, 8'($urandom),
                               16'($urandom), 16'd0, 1'b0);
                send_wire_bytes();
            end
        end

        drain();
        if (results_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS chunk_deframer_fletcher16_unit");
        else
            $display("FAIL chunk_deframer_fletcher16_unit");
        $finish;
    end

endmodule
